// ----- hw/rtl/buddy_block_allocator_unit_macros.svh -----
// Assertion macros for the buddy block allocator checker.
// Included by files that hold concurrent assertions; needs clk and rst_n in scope.
`ifndef BUDDY_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define BBA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/bba_pkg.sv -----
// Shared constants, codes and helpers for the buddy block allocator.
// No dependencies; used by the top level and by its checker.
`timescale 1ns / 1ps

package bba_pkg;

  // Pool geometry
  localparam int POOL_LOG2  = 6;
  localparam int POOL_UNITS = 1 << POOL_LOG2;
  localparam int NODES      = 2 * POOL_UNITS - 1;
  localparam int NODE_W     = POOL_LOG2 + 1;
  localparam int UNIT_W     = POOL_LOG2 + 1;
  localparam int OFF_W      = POOL_LOG2;

  // Field widths
  localparam int ACT_W    = 2;
  localparam int REQ_W    = 16;
  localparam int STATUS_W = 2;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FREE  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NO_SPACE = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_BAD_OFFS = 2'd2;

  // Round a request up to a power of two; zero counts as one.
  // Caller guarantees req <= POOL_UNITS.
  function automatic logic [UNIT_W-1:0] round_pow2(input logic [REQ_W-1:0] req);
    logic [UNIT_W-1:0] p;
    int k;
    p = UNIT_W'(POOL_UNITS);
    for (k = POOL_LOG2 - 1; k >= 0; k--) begin
      if (req <= REQ_W'(1 << k)) begin
        p = UNIT_W'(1 << k);
      end
    end
    return p;
  endfunction

endpackage

// ----- hw/rtl/buddy_block_allocator_unit.sv -----
// Buddy block allocator: one word in, one word out, tree kept in an on-chip RAM.
// Depends on bba_pkg.
`timescale 1ns / 1ps

// Buddy allocator over a 64-unit pool, held as a 127-node heap-ordered tree of
// largest-free-run values in a RAM with one write and two registered reads per
// cycle. Each word takes one trip through a small sequencer and in_stall stays
// high until the result is queued in the output register. An allocate of size
// 2^k walks down 6-k levels and then back up to the root, updating each parent;
// a query climbs from the leaf to the owning block; a free then also climbs back
// up to the root. Each step waits on a registered RAM read. Per-node valid bits
// cleared at reset stand in for the initial capacities, so no clearing pass is
// needed.
module buddy_block_allocator_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  // request channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [bba_pkg::ACT_W-1:0]      in_action,
  input  logic [bba_pkg::REQ_W-1:0]      in_req_size,
  input  logic [bba_pkg::OFF_W-1:0]      in_block_offset,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [bba_pkg::STATUS_W-1:0]   out_status,
  output logic [bba_pkg::OFF_W-1:0]      out_alloc_offset,
  output logic [bba_pkg::UNIT_W-1:0]     out_block_units
);

  localparam int NODE_W = bba_pkg::NODE_W;
  localparam int UNIT_W = bba_pkg::UNIT_W;
  localparam int OFF_W  = bba_pkg::OFF_W;
  localparam logic [UNIT_W-1:0] POOL_SZ   = UNIT_W'(bba_pkg::POOL_UNITS);
  localparam logic [NODE_W-1:0] LEAF_BASE = NODE_W'(bba_pkg::POOL_UNITS - 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROOT_RD,
    ST_ROOT_CHK,
    ST_DESC_RD,
    ST_DESC_CHK,
    ST_MARK,
    ST_UP_RD,
    ST_UP_WR,
    ST_FIND_RD,
    ST_FIND_CHK,
    ST_RESP
  } state_t;

  state_t state_r;

  // working registers
  logic [bba_pkg::ACT_W-1:0]    act_r;
  logic [NODE_W-1:0]            idx_r;
  logic [UNIT_W-1:0]            sz_r;
  logic [UNIT_W-1:0]            need_r;
  logic [UNIT_W-1:0]            cur_r;
  logic [OFF_W-1:0]             aoff_r;
  logic [bba_pkg::STATUS_W-1:0] res_status_r;
  logic [UNIT_W-1:0]            res_units_r;

  // output register
  logic                         out_valid_r;
  logic [bba_pkg::STATUS_W-1:0] out_status_r;
  logic [OFF_W-1:0]             out_alloc_offset_r;
  logic [UNIT_W-1:0]            out_block_units_r;

  // tree RAM and per-node valid bits
  logic [UNIT_W-1:0] tree_mem [bba_pkg::NODES];
  logic [bba_pkg::NODES-1:0] vld_r;
  logic [NODE_W-1:0] rd_a_addr, rd_b_addr, wr_addr;
  logic              wr_en;
  logic [UNIT_W-1:0] wr_data;
  logic [UNIT_W-1:0] rd_a_q_r, rd_b_q_r;
  logic              rd_a_vld_r, rd_b_vld_r;

  // derived values
  logic [UNIT_W-1:0] cap_a, cap_b, val_a, val_b;
  logic [NODE_W-1:0] left_idx, right_idx, sib_idx, par_idx;
  logic [UNIT_W-1:0] up_sz, run_max, up_val;
  logic [UNIT_W:0]   pair_sum;
  logic              go_left;

  assign in_stall         = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_alloc_offset = out_alloc_offset_r;
  assign out_block_units  = out_block_units_r;

  // Node addressing around idx_r
  assign left_idx  = {idx_r[NODE_W-2:0], 1'b1};
  assign right_idx = left_idx + NODE_W'(1);
  assign sib_idx   = idx_r[0] ? idx_r + NODE_W'(1) : idx_r - NODE_W'(1);
  assign par_idx   = (idx_r - NODE_W'(1)) >> 1;
  assign up_sz     = {sz_r[UNIT_W-2:0], 1'b0};

  // Never-written nodes read as their subtree capacity
  assign cap_a = (state_r == ST_DESC_CHK) ? (sz_r >> 1) : sz_r;
  assign cap_b = sz_r >> 1;
  assign val_a = rd_a_vld_r ? rd_a_q_r : cap_a;
  assign val_b = rd_b_vld_r ? rd_b_q_r : cap_b;

  // Descent choice: smaller fitting run, ties left
  assign go_left = (val_a >= need_r) && ((val_b < need_r) || (val_a <= val_b));

  // Parent update on the way up; a free merges buddies that are both whole
  assign run_max  = (cur_r >= val_a) ? cur_r : val_a;
  assign pair_sum = {1'b0, cur_r} + {1'b0, val_a};
  assign up_val   = ((act_r == bba_pkg::ACT_FREE) && (pair_sum == {1'b0, up_sz}))
                    ? up_sz : run_max;

  // RAM port control
  always_comb begin
    rd_a_addr = idx_r;
    rd_b_addr = '0;
    wr_en     = 1'b0;
    wr_addr   = idx_r;
    wr_data   = '0;
    unique case (state_r)
      ST_DESC_RD: begin
        if (sz_r != need_r) begin
          rd_a_addr = left_idx;
          rd_b_addr = right_idx;
        end
      end
      ST_UP_RD: begin
        if (idx_r != '0) begin
          rd_a_addr = sib_idx;
        end
      end
      ST_MARK: begin
        wr_en = 1'b1;
      end
      ST_UP_WR: begin
        wr_en   = 1'b1;
        wr_addr = par_idx;
        wr_data = up_val;
      end
      ST_FIND_CHK: begin
        wr_en   = (val_a == '0) && (act_r == bba_pkg::ACT_FREE);
        wr_data = sz_r;
      end
      default: begin
      end
    endcase
  end

  // Tree RAM: one write, two registered reads
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tree_mem[wr_addr] <= wr_data;
    end
    rd_a_q_r   <= tree_mem[rd_a_addr];
    rd_b_q_r   <= tree_mem[rd_b_addr];
    rd_a_vld_r <= vld_r[rd_a_addr];
    rd_b_vld_r <= vld_r[rd_b_addr];
  end

  // Valid bits: set on first write, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // ST_RESP reloads the output register itself
      if (out_valid_r && !out_stall && state_r != ST_RESP) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            act_r        <= in_action;
            aoff_r       <= '0;
            res_units_r  <= '0;
            priority if (in_action == bba_pkg::ACT_ALLOC) begin
              idx_r <= '0;
              sz_r  <= POOL_SZ;
              if (in_req_size > bba_pkg::REQ_W'(bba_pkg::POOL_UNITS)) begin
                res_status_r <= bba_pkg::STAT_NO_SPACE;
                state_r      <= ST_RESP;
              end else begin
                need_r  <= bba_pkg::round_pow2(in_req_size);
                state_r <= ST_ROOT_RD;
              end
            end else if (in_action == bba_pkg::ACT_FREE ||
                         in_action == bba_pkg::ACT_QUERY) begin
              res_status_r <= bba_pkg::STAT_BAD_OFFS;
              idx_r        <= NODE_W'(in_block_offset) + LEAF_BASE;
              sz_r         <= UNIT_W'(1);
              state_r      <= ST_FIND_RD;
            end else begin
              res_status_r <= bba_pkg::STAT_BAD_OFFS;
              state_r      <= ST_RESP;
            end
          end
        end
        ST_ROOT_RD: begin
          state_r <= ST_ROOT_CHK;
        end
        ST_ROOT_CHK: begin
          if (val_a < need_r) begin
            res_status_r <= bba_pkg::STAT_NO_SPACE;
            state_r      <= ST_RESP;
          end else begin
            state_r <= ST_DESC_RD;
          end
        end
        ST_DESC_RD: begin
          state_r <= (sz_r == need_r) ? ST_MARK : ST_DESC_CHK;
        end
        ST_DESC_CHK: begin
          if (go_left) begin
            idx_r <= left_idx;
          end else begin
            idx_r  <= right_idx;
            aoff_r <= aoff_r + OFF_W'(sz_r >> 1);
          end
          sz_r    <= sz_r >> 1;
          state_r <= ST_DESC_RD;
        end
        ST_MARK: begin
          cur_r        <= '0;
          res_status_r <= bba_pkg::STAT_OK;
          res_units_r  <= need_r;
          state_r      <= ST_UP_RD;
        end
        ST_UP_RD: begin
          state_r <= (idx_r == '0) ? ST_RESP : ST_UP_WR;
        end
        ST_UP_WR: begin
          cur_r   <= up_val;
          idx_r   <= par_idx;
          sz_r    <= up_sz;
          state_r <= ST_UP_RD;
        end
        ST_FIND_RD: begin
          state_r <= ST_FIND_CHK;
        end
        ST_FIND_CHK: begin
          if (val_a == '0) begin
            // owning block found
            res_status_r <= bba_pkg::STAT_OK;
            res_units_r  <= sz_r;
            if (act_r == bba_pkg::ACT_FREE) begin
              cur_r   <= sz_r;
              state_r <= ST_UP_RD;
            end else begin
              state_r <= ST_RESP;
            end
          end else if (idx_r == '0) begin
            state_r <= ST_RESP;
          end else begin
            idx_r   <= par_idx;
            sz_r    <= up_sz;
            state_r <= ST_FIND_RD;
          end
        end
        ST_RESP: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r        <= 1'b1;
            out_status_r       <= res_status_r;
            out_alloc_offset_r <= aoff_r;
            out_block_units_r  <= res_units_r;
            state_r            <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/bba_chk.sv -----
// Port-level checker for the buddy block allocator, bound to the top level.
// Depends on bba_pkg and buddy_block_allocator_unit_macros.svh.
`timescale 1ns / 1ps
`include "buddy_block_allocator_unit_macros.svh"

module bba_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [bba_pkg::STATUS_W-1:0]   out_status,
  input logic [bba_pkg::OFF_W-1:0]      out_alloc_offset,
  input logic [bba_pkg::UNIT_W-1:0]     out_block_units
);

  localparam int WORD_W = bba_pkg::STATUS_W + bba_pkg::OFF_W + bba_pkg::UNIT_W;

  // result word views
  logic                      ok_word;
  logic                      bad_word;
  logic                      no_payload;
  logic [bba_pkg::OFF_W-1:0] unit_mask;
  logic [WORD_W-1:0]         out_word;

  assign ok_word    = out_valid && (out_status == bba_pkg::STAT_OK);
  assign bad_word   = out_valid && (out_status != bba_pkg::STAT_OK);
  assign no_payload = (out_alloc_offset == '0) && (out_block_units == '0);
  assign unit_mask  = bba_pkg::OFF_W'(out_block_units - bba_pkg::UNIT_W'(1));
  assign out_word   = {out_status, out_alloc_offset, out_block_units};

  // busy right after taking a word
  `BBA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "idle after accept")

  // failed requests carry no offset and no size
  `BBA_ASSERT_NOW(a_fail_zero, bad_word, no_payload, "failed result carries payload")

  // a good result names a power-of-two block
  `BBA_ASSERT_NOW(a_ok_pow2, ok_word, $onehot(out_block_units), "block size not a power of two")

  // a block starts on a boundary of its own size
  `BBA_ASSERT_NOW(a_ok_aligned, ok_word, (out_alloc_offset & unit_mask) == '0, "misaligned")

  // stalled result word holds
  `BBA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word), "changed")

endmodule

bind buddy_block_allocator_unit bba_chk u_bba_chk (.*);
